/* hdl/r2fft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, codes and elaboration-time twiddle helpers for the radix-2 core.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  // width of one stored real or imaginary value
  localparam int STORE_BITS = 27;

  // pi in Q30
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // register indexes
  localparam logic REG_POINTS_LOG2  = 1'b0;
  localparam logic REG_INVERSE_MODE = 1'b1;

  // input beat kinds
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PULL,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WP,
    ST_BF_WQ
  } state_t;

  // unsigned quotient by restoring shift and subtract, evaluated at elaboration
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((num >> i) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  // round a Q30 value to Q1.(twb-1), nearest with ties away from zero, saturated
  function automatic longint tw_round(input longint v, input int twb);
    int              sh;
    longint          r;
    longint          hi;
    longint          lo;
    bit              neg;
    longint unsigned mag;
    sh = 30 - (twb - 1);
    if (sh > 0) begin
      neg = (v < 0);
      mag = neg ? longint'(-v) : longint'(v);
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      r   = neg ? -longint'(mag) : longint'(mag);
    end else if (sh == 0) begin
      r = v;
    end else begin
      r = v * 2;
    end
    hi = (longint'(1) <<< (twb - 1)) - 1;
    lo = -(longint'(1) <<< (twb - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  // twiddle cos or sin of 2*pi*k/2^maxl, series evaluation in Q30
  function automatic longint tw_value(input longint unsigned k, input int maxl,
                                      input int twb, input bit want_sin);
    longint unsigned m;
    longint unsigned kk;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned ts;
    longint unsigned tc;
    longint          ss;
    longint          cs;
    m  = 64'd1 << maxl;
    kk = (4 * k <= m) ? k : (m / 2 - k);
    a  = (PI_Q30 * 2 * kk + (m >> 1)) >> maxl;
    a2 = (a * a) >> 30;
    ts = a;
    tc = 64'd1 << 30;
    ss = longint'(a);
    cs = longint'(tc);
    for (int n = 1; n <= 12; n++) begin
      ts = udiv((ts * a2) >> 30, longint'((2 * n) * (2 * n + 1)));
      tc = udiv((tc * a2) >> 30, longint'((2 * n - 1) * (2 * n)));
      if ((n % 2) == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    if (kk != k) cs = -cs;
    return tw_round(want_sin ? ss : cs, twb);
  endfunction

endpackage

/* hdl/radix2_fft_ifft_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_ifft_core
// Power-of-two complex FFT / inverse FFT with an in-place sample memory.
// ----------------------------------------------------------------------------
// Push beats load samples, written straight to bit-reversed addresses. The
// push that completes the frame starts the transform: (N/2)*log2(N)
// butterflies, each stepping through read, multiply, add and two writes
// (through the single memory write port), during which no beat is accepted.
// A pull goes through a memory read and the output register; the inverse 1/N
// scaling is applied on the way out. The output register lets pushes proceed
// while a bin waits to be taken.
module radix2_fft_ifft_core
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS_LOG2 = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int TWIDDLE_BITS    = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // sample_real, sample_imag
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // action
  input  logic                 s_tuser,
  // bin stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // bin_real, bin_imag, bin_index
  output logic [((2*STORE_BITS+MAX_POINTS_LOG2+7)/8)*8-1:0] m_tdata,
  // bin_valid
  output logic                 m_tuser,
  output logic                 m_tlast,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int AW        = MAX_POINTS_LOG2;
  localparam int M         = 1 << AW;
  localparam int TW_AW     = (AW > 1) ? AW - 1 : 1;
  localparam int ROM_DEPTH = 1 << TW_AW;
  localparam int TW_FRAC   = TWIDDLE_BITS - 1;
  localparam int LGW       = $clog2(MAX_POINTS_LOG2 + 1);
  localparam int SW        = STORE_BITS;
  localparam int PW        = SW + TWIDDLE_BITS;
  localparam int SUMW      = PW + 1;
  localparam int TRW       = SUMW - TW_FRAC;
  localparam int ODW       = ((2*STORE_BITS+MAX_POINTS_LOG2+7)/8)*8;
  localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (TW_FRAC - 1);

  function automatic logic signed [SW-1:0] sat_store(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -(longint'(1) <<< (SW - 1));
    if (v > hi) return SW'(hi);
    if (v < lo) return SW'(lo);
    return SW'(v);
  endfunction

  // twiddle rom
  logic [TWIDDLE_BITS-1:0] rom_cos [ROM_DEPTH];
  logic [TWIDDLE_BITS-1:0] rom_sin [ROM_DEPTH];
  for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
    localparam longint CV = tw_value(k, MAX_POINTS_LOG2, TWIDDLE_BITS, 1'b0);
    localparam longint SV = tw_value(k, MAX_POINTS_LOG2, TWIDDLE_BITS, 1'b1);
    assign rom_cos[k] = CV[TWIDDLE_BITS-1:0];
    assign rom_sin[k] = SV[TWIDDLE_BITS-1:0];
  end

  // registers
  state_t              state, state_next;
  logic [3:0]          points_log2;
  logic                inverse_mode;
  logic [AW:0]         load_count;
  logic [AW-1:0]       read_pointer;
  logic                result_ready;
  logic [LGW-1:0]      st;
  logic [AW-1:0]       bf;
  logic                pull_hit;
  logic [AW-1:0]       out_idx_q;
  logic                out_last_q;
  logic signed [SW-1:0] out_real, out_imag;
  logic [AW-1:0]       out_idx;
  logic                out_valid, out_last;

  // memory, {imag, real}
  logic [2*SW-1:0]     mem [M];
  logic [2*SW-1:0]     rd_a_q, rd_b_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa, rd_a_addr, rd_b_addr;
  logic [2*SW-1:0]     mem_wd;

  // datapath registers
  logic signed [TWIDDLE_BITS-1:0] tw_c, tw_s;
  logic signed [PW-1:0] p_cbr, p_sbi, p_cbi, p_sbr;
  logic signed [SW-1:0] ar_q, ai_q;
  logic [2*SW-1:0]     wp_data, wq_data;

  // effective length
  logic [LGW-1:0]      lg;
  logic [AW-1:0]       last_idx;
  always_comb begin
    if (points_log2 == 4'd0) lg = LGW'(1);
    else if (int'(points_log2) > MAX_POINTS_LOG2) lg = LGW'(MAX_POINTS_LOG2);
    else lg = LGW'(points_log2);
    last_idx = {AW{1'b1}} >> (AW - int'(lg));
  end

  // handshakes
  logic push_acc, pull_acc, cfg_we, out_free;
  assign push_acc = s_tvalid && s_tready && (s_tuser == ACT_PUSH);
  assign pull_acc = s_tvalid && s_tready && (s_tuser == ACT_PULL);
  assign cfg_we   = psel && penable && pwrite;
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_INVERSE_MODE) ? {31'd0, inverse_mode}
                                                   : {28'd0, points_log2};

  // load address, bit reversed over the active length
  logic [AW-1:0] ld_idx, rev_full, ld_rev;
  always_comb begin
    ld_idx = result_ready ? '0 : load_count[AW-1:0];
    for (int i = 0; i < AW; i++) rev_full[i] = ld_idx[AW-1-i];
    ld_rev = rev_full >> (AW - int'(lg));
  end

  // incoming sample, conjugated in inverse mode
  logic signed [SAMPLE_BITS:0] in_re, in_im;
  logic signed [SW-1:0]        ld_re, ld_im;
  always_comb begin
    in_re = {s_tdata[SAMPLE_BITS-1], s_tdata[SAMPLE_BITS-1:0]};
    in_im = {s_tdata[2*SAMPLE_BITS-1], s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]};
    if (inverse_mode) in_im = -in_im;
    ld_re = sat_store(longint'(in_re));
    ld_im = sat_store(longint'(in_im));
  end

  // butterfly addressing
  logic [AW-1:0]    h_bit, h_mask, bf_p, bf_q, bf_j, bf_last;
  logic [TW_AW-1:0] tw_addr;
  always_comb begin
    h_bit   = AW'(1) << st;
    h_mask  = h_bit - AW'(1);
    bf_j    = bf & h_mask;
    bf_p    = ((bf & ~h_mask) << 1) | bf_j;
    bf_q    = bf_p | h_bit;
    tw_addr = TW_AW'(bf_j << (MAX_POINTS_LOG2 - 1 - int'(st)));
    bf_last = last_idx >> 1;
  end

  // sequencer: next state and memory control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = ld_rev;
    mem_wd     = {ld_im, ld_re};
    rd_a_addr  = bf_p;
    rd_b_addr  = bf_q;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        rd_a_addr = read_pointer;
        if (push_acc) begin
          mem_we = 1'b1;
          if (ld_idx == last_idx) state_next = ST_BF_RD;
        end else if (pull_acc) begin
          state_next = ST_PULL;
        end
      end
      ST_PULL: begin
        rd_a_addr = out_idx_q;
        if (out_free) state_next = ST_IDLE;
      end
      ST_BF_RD:  state_next = ST_BF_MUL;
      ST_BF_MUL: state_next = ST_BF_ADD;
      ST_BF_ADD: state_next = ST_BF_WP;
      ST_BF_WP: begin
        mem_we     = 1'b1;
        mem_wa     = bf_p;
        mem_wd     = wp_data;
        state_next = ST_BF_WQ;
      end
      ST_BF_WQ: begin
        mem_we = 1'b1;
        mem_wa = bf_q;
        mem_wd = wq_data;
        if (bf == bf_last && st == lg - LGW'(1)) state_next = ST_IDLE;
        else state_next = ST_BF_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  // twiddle read
  always_ff @(posedge clk) begin
    tw_c <= rom_cos[tw_addr];
    tw_s <= rom_sin[tw_addr];
  end

  // butterfly multiply stage
  logic signed [SW-1:0] br, bi;
  assign br = rd_b_q[SW-1:0];
  assign bi = rd_b_q[2*SW-1:SW];
  always_ff @(posedge clk) begin
    p_cbr <= tw_c * br;
    p_sbi <= tw_s * bi;
    p_cbi <= tw_c * bi;
    p_sbr <= tw_s * br;
    ar_q  <= rd_a_q[SW-1:0];
    ai_q  <= rd_a_q[2*SW-1:SW];
  end

  // butterfly round, add and saturate stage
  logic signed [SUMW-1:0] sum_r, sum_i, sh_r, sh_i;
  logic signed [TRW-1:0]  tr, ti;
  logic signed [TRW:0]    sp_r, sp_i, sq_r, sq_i;
  always_comb begin
    sum_r = p_cbr + p_sbi + HALF;
    sum_i = p_cbi - p_sbr + HALF;
    sh_r  = sum_r >>> TW_FRAC;
    sh_i  = sum_i >>> TW_FRAC;
    tr    = sh_r[TRW-1:0];
    ti    = sh_i[TRW-1:0];
    sp_r  = ar_q + tr;
    sp_i  = ai_q + ti;
    sq_r  = ar_q - tr;
    sq_i  = ai_q - ti;
  end
  always_ff @(posedge clk) begin
    wp_data <= {sat_store(longint'(sp_i)), sat_store(longint'(sp_r))};
    wq_data <= {sat_store(longint'(sq_i)), sat_store(longint'(sq_r))};
  end

  // output formatting, inverse scaling on the way out
  logic signed [SW-1:0] rd_re, rd_im, fmt_re, fmt_im;
  always_comb begin
    rd_re = rd_a_q[SW-1:0];
    rd_im = rd_a_q[2*SW-1:SW];
    if (inverse_mode) begin
      fmt_re = rd_re >>> lg;
      fmt_im = sat_store(-longint'(rd_im)) >>> lg;
    end else begin
      fmt_re = rd_re;
      fmt_im = rd_im;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PULL && out_free) begin
      out_real <= pull_hit ? fmt_re : '0;
      out_imag <= pull_hit ? fmt_im : '0;
      out_idx  <= pull_hit ? out_idx_q : '0;
      out_valid <= pull_hit;
      out_last  <= pull_hit && out_last_q;
    end
    if (pull_acc) begin
      pull_hit   <= result_ready;
      out_idx_q  <= read_pointer;
      out_last_q <= (read_pointer == last_idx);
    end
  end

  assign m_tdata = ODW'({out_idx, out_imag, out_real});
  assign m_tuser = out_valid;
  assign m_tlast = out_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      points_log2  <= 4'd7;
      inverse_mode <= 1'b0;
      load_count   <= '0;
      read_pointer <= '0;
      result_ready <= 1'b0;
      st           <= '0;
      bf           <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_PULL && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      // register write drops the current frame
      if (cfg_we) begin
        if (paddr[2] == REG_POINTS_LOG2) points_log2 <= pwdata[3:0];
        else inverse_mode <= pwdata[0];
        load_count   <= '0;
        read_pointer <= '0;
        result_ready <= 1'b0;
      end else begin
        if (push_acc) begin
          load_count <= {1'b0, ld_idx} + (AW+1)'(1);
          if (result_ready) begin
            result_ready <= 1'b0;
            read_pointer <= '0;
          end
          st <= '0;
          bf <= '0;
        end
        if (pull_acc && result_ready) begin
          if (read_pointer == last_idx) begin
            load_count   <= '0;
            read_pointer <= '0;
            result_ready <= 1'b0;
          end else begin
            read_pointer <= read_pointer + AW'(1);
          end
        end
        if (state == ST_BF_WQ) begin
          if (bf == bf_last) begin
            bf <= '0;
            if (st == lg - LGW'(1)) result_ready <= 1'b1;
            else st <= st + LGW'(1);
          end else begin
            bf <= bf + AW'(1);
          end
        end
      end
    end
  end

endmodule

/* dv/r2fft_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_checker
// Watches the sample, bin and register ports of the radix-2 core, keeps its
// own fixed-point transform model and compares every bin beat with the oldest
// predicted bin.
// ----------------------------------------------------------------------------
module r2fft_checker
  import r2fft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);

  localparam int MAXL = 10;
  localparam int MAXN = 1 << MAXL;

  typedef struct {
    logic signed [26:0] re;
    logic signed [26:0] im;
    logic [9:0]         idx;
    logic               vld;
    logic               lst;
  } bin_t;

  bin_t   bin_queue[$];
  longint cos_rom[0:MAXN/2-1];
  longint sin_rom[0:MAXN/2-1];
  longint real_mem[0:MAXN-1];
  longint imag_mem[0:MAXN-1];
  logic [3:0] points_reg;
  logic       inverse_reg;
  int unsigned fill_cnt;
  int unsigned rd_ptr;
  bit          frame_done;

  function automatic longint sat27(input longint x);
    if (x > 64'sd67108863) return 64'sd67108863;
    if (x < -64'sd67108864) return -64'sd67108864;
    return x;
  endfunction

  // q30 value to q1.15 twiddle, round half away from zero, saturated
  function automatic longint q15_round(input longint v);
    longint unsigned mag;
    longint r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag + 64'd16384) >> 15;
    r = (v < 0) ? -longint'(mag) : longint'(mag);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  initial begin
    longint unsigned kk, a, a2, ts, tc;
    longint ss, cs;
    for (int k = 0; k < MAXN / 2; k++) begin
      kk = (4 * k <= MAXN) ? k : MAXN / 2 - k;
      a  = (PI_Q30 * 2 * kk + MAXN / 2) >> MAXL;
      a2 = (a * a) >> 30;
      ts = a;
      tc = 64'd1 << 30;
      ss = longint'(a);
      cs = longint'(tc);
      for (int n = 1; n <= 12; n++) begin
        ts = ((ts * a2) >> 30) / longint'((2 * n) * (2 * n + 1));
        tc = ((tc * a2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2) begin
          ss -= longint'(ts);
          cs -= longint'(tc);
        end else begin
          ss += longint'(ts);
          cs += longint'(tc);
        end
      end
      if (kk != k) cs = -cs;
      cos_rom[k] = q15_round(cs);
      sin_rom[k] = q15_round(ss);
    end
  end

  function automatic int active_log2();
    if (points_reg < 1) return 1;
    if (points_reg > MAXL) return MAXL;
    return points_reg;
  endfunction

  // in-place decimation-in-time transform over the first 2^lg entries
  task automatic run_transform(input int lg);
    int n, r, h, p, q, ti;
    longint c, s, t, tr, tim, ar, ai;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int j = 0; j < lg; j++) r |= ((i >> j) & 1) << (lg - 1 - j);
      if (r > i) begin
        t = real_mem[i]; real_mem[i] = real_mem[r]; real_mem[r] = t;
        t = imag_mem[i]; imag_mem[i] = imag_mem[r]; imag_mem[r] = t;
      end
    end
    for (int st = 0; st < lg; st++) begin
      h = 1 << st;
      for (int i = 0; i < n; i += 2 * h) begin
        for (int j = 0; j < h; j++) begin
          p  = i + j;
          q  = p + h;
          ti = (j << (MAXL - st - 1)) & (MAXN - 1);
          c  = cos_rom[ti];
          s  = sin_rom[ti];
          tr  = (c * real_mem[q] + s * imag_mem[q] + 16384) >>> 15;
          tim = (c * imag_mem[q] - s * real_mem[q] + 16384) >>> 15;
          ar = real_mem[p];
          ai = imag_mem[p];
          real_mem[p] = sat27(ar + tr);
          imag_mem[p] = sat27(ai + tim);
          real_mem[q] = sat27(ar - tr);
          imag_mem[q] = sat27(ai - tim);
        end
      end
    end
    if (inverse_reg) begin
      for (int i = 0; i < n; i++) begin
        imag_mem[i] = sat27(-imag_mem[i]) >>> lg;
        real_mem[i] = real_mem[i] >>> lg;
      end
    end
  endtask

  task automatic predict_push(input logic [15:0] re_in, input logic [15:0] im_in);
    longint re, im;
    int lg;
    lg = active_log2();
    re = longint'($signed(re_in));
    im = longint'($signed(im_in));
    if (frame_done) begin
      fill_cnt = 0; rd_ptr = 0; frame_done = 0;
    end
    if (inverse_reg) im = -im;
    real_mem[fill_cnt % MAXN] = sat27(re);
    imag_mem[fill_cnt % MAXN] = sat27(im);
    fill_cnt++;
    if (fill_cnt >= (1 << lg)) begin
      run_transform(lg);
      frame_done = 1;
    end
  endtask

  task automatic predict_pull();
    bin_t b;
    int n;
    n = 1 << active_log2();
    b = '{re: '0, im: '0, idx: '0, vld: 1'b0, lst: 1'b0};
    if (frame_done) begin
      b.re  = real_mem[rd_ptr][26:0];
      b.im  = imag_mem[rd_ptr][26:0];
      b.idx = rd_ptr[9:0];
      b.vld = 1'b1;
      b.lst = (rd_ptr >= n - 1);
      if (b.lst) begin
        fill_cnt = 0; rd_ptr = 0; frame_done = 0;
      end else begin
        rd_ptr++;
      end
    end
    bin_queue.push_back(b);
  endtask

  // beat monitor: bins out, samples and pulls in, register writes
  always @(posedge clk) begin
    bin_t exp_b;
    if (rst) begin
      points_reg  = 4'd7;
      inverse_reg = 1'b0;
      fill_cnt = 0; rd_ptr = 0; frame_done = 0;
      bin_queue.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bin_queue.size() == 0) begin
          $display("%0t: unexpected bin beat re=%0d im=%0d idx=%0d vld=%0b last=%0b",
                   $time, $signed(m_tdata[26:0]), $signed(m_tdata[53:27]),
                   m_tdata[63:54], m_tuser, m_tlast);
          errors++;
        end else begin
          exp_b = bin_queue.pop_front();
          if (m_tdata[26:0] !== exp_b.re || m_tdata[53:27] !== exp_b.im ||
              m_tdata[63:54] !== exp_b.idx || m_tuser !== exp_b.vld ||
              m_tlast !== exp_b.lst) begin
            $display("%0t: bin mismatch expected re=%0d im=%0d idx=%0d vld=%0b last=%0b",
                     $time, exp_b.re, exp_b.im, exp_b.idx, exp_b.vld, exp_b.lst);
            $display("%0t:              actual   re=%0d im=%0d idx=%0d vld=%0b last=%0b",
                     $time, $signed(m_tdata[26:0]), $signed(m_tdata[53:27]),
                     m_tdata[63:54], m_tuser, m_tlast);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_PUSH) predict_push(s_tdata[15:0], s_tdata[31:16]);
        else predict_pull();
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_POINTS_LOG2) points_reg = pwdata[3:0];
        else inverse_reg = pwdata[0];
        fill_cnt = 0; rd_ptr = 0; frame_done = 0;
      end
    end
    pending = bin_queue.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the radix-2 FFT/IFFT core with directed and random frames over many
// lengths and both directions, with random gaps on both streams; the checker
// predicts every bin and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import r2fft_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] ADDR_POINTS  = {REG_POINTS_LOG2, 2'b00};
  localparam logic [2:0] ADDR_INVERSE = {REG_INVERSE_MODE, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // sample_real, sample_imag
  logic        s_tuser = ACT_PUSH;  // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // bin_real, bin_imag, bin_index
  logic        m_tuser;        // bin_valid
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          beats_sent = 0;
  int          cur_len = 128;
  bit          big_done = 0;

  always #5 clk = ~clk;

  radix2_fft_ifft_core i_dut (.*);

  r2fft_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  // run timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // bin side back-pressure, alternating ready and stall stretches
  int ready_left = 0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        ready_left <= gap_len() + 1;
      end else begin
        m_tready   <= 1'b1;
        ready_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 8);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h7fff;
    if (r < 16) return 16'h8000;
    if (r < 26) return 16'($signed($urandom_range(0, 16)) - 8);
    return 16'($urandom);
  endfunction

  // one beat on the sample stream, caller sits at a falling edge
  task automatic send_beat(input logic act, input logic [15:0] re, input logic [15:0] im);
    int g;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {im, re};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    beats_sent++;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic push_beat(input logic [15:0] re, input logic [15:0] im);
    send_beat(ACT_PUSH, re, im);
  endtask

  task automatic pull_beat();
    send_beat(ACT_PULL, 16'($urandom), 16'($urandom));
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    s_tvalid <= 1'b0;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    if (addr == ADDR_POINTS) begin
      if (val[3:0] == 0) cur_len = 2;
      else if (val[3:0] > 10) cur_len = 1024;
      else cur_len = 1 << val[3:0];
    end
  endtask

  // bins drained, then a short settle for a pending output register
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic full_frame(input int extra_pulls);
    repeat (cur_len) push_beat(pick_sample(), pick_sample());
    repeat (cur_len + extra_pulls) pull_beat();
  endtask

  initial begin
    int r, k, v;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: early pull, extremes, inverse saturation, drop, length clamp
    reg_write(ADDR_POINTS, 32'd1);
    reg_write(ADDR_INVERSE, 32'd0);
    pull_beat();
    push_beat(16'h7fff, 16'h8000);
    push_beat(16'h8000, 16'h7fff);
    repeat (3) pull_beat();
    wait_drained();
    reg_write(ADDR_INVERSE, 32'd1);
    push_beat(16'h8000, 16'h8000);
    push_beat(16'h7fff, 16'h0000);
    pull_beat();
    push_beat(16'h0001, 16'hffff);
    push_beat(16'h8000, 16'h7fff);
    repeat (2) pull_beat();
    wait_drained();
    reg_write(ADDR_POINTS, 32'd0);
    reg_write(ADDR_INVERSE, 32'd0);
    push_beat(16'h7fff, 16'h7fff);
    pull_beat();
    push_beat(16'h8000, 16'h8000);
    repeat (2) pull_beat();
    wait_drained();
    reg_write(ADDR_POINTS, 32'd2);
    repeat (4) push_beat(16'h7fff, 16'h7fff);
    repeat (4) pull_beat();
    wait_drained();

    // random frames
    while (beats_sent < 1950) begin
      if (!big_done && beats_sent > 150) begin
        // one longest frame, partly read out, dropped by the next length write
        reg_write(ADDR_POINTS, $urandom_range(0, 1) ? 32'd15 : 32'd10);
        big_done = 1;
        if ($urandom_range(0, 2) == 0) reg_write(ADDR_INVERSE, 32'($urandom_range(0, 1)));
        repeat (cur_len) push_beat(pick_sample(), pick_sample());
        repeat ($urandom_range(64, 160)) pull_beat();
        wait_drained();
        continue;
      end
      if (cur_len >= 512 || $urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 99);
        v = (r < 90 || beats_sent > 1000) ? $urandom_range(0, 6) : $urandom_range(7, 8);
        reg_write(ADDR_POINTS, 32'(v) | (32'($urandom) & 32'hfffffff0) & 32'h0);
      end
      if ($urandom_range(0, 2) == 0) reg_write(ADDR_INVERSE, 32'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 9) == 0) pull_beat();
        full_frame(($urandom_range(0, 6) == 0) ? 1 : 0);
      end else if (r < 90) begin
        // partial read-out, then a new frame drops the rest
        repeat (cur_len) push_beat(pick_sample(), pick_sample());
        k = $urandom_range(0, cur_len - 1);
        repeat (k) pull_beat();
        repeat ($urandom_range(1, cur_len)) push_beat(pick_sample(), pick_sample());
        pull_beat();
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1)) push_beat(pick_sample(), pick_sample());
          else pull_beat();
        end
        pull_beat();
      end
      wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* radix2_fft_ifft_core.f */
hdl/r2fft_pkg.sv
hdl/radix2_fft_ifft_core.sv
dv/r2fft_checker.sv
dv/testbench.sv
